[hdl/drtu_pkg.sv]
// ----------------------------------------------------------------------------
// drtu_pkg
// Types, register addresses and the control store of the divider and reload
// timer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package drtu_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [15:0] addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  pc_t;
  typedef logic [10:0] acc_t;

  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_READ  = 2'd1;
  localparam mode_t MODE_WRITE = 2'd2;
  localparam mode_t MODE_TAKE  = 2'd3;

  localparam addr_t ADDR_DIVIDER = 16'hFF04;
  localparam addr_t ADDR_COUNTER = 16'hFF05;
  localparam addr_t ADDR_RELOAD  = 16'hFF06;
  localparam addr_t ADDR_CONTROL = 16'hFF07;

  localparam byte_t BYTE_ALL_ONES = 8'hFF;
  localparam logic [4:0] CTL_UPPER_ONES = 5'h1F;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK_START,
    OP_COUNT,
    OP_READ,
    OP_WRITE,
    OP_TAKE
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_TIMER_OFF,
    COND_ACC_GE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  last;
  } ctrl_word_t;

  typedef struct packed {
    logic timer_off;
    logic acc_ge;
  } seq_status_t;

  localparam pc_t PC_TICK_START = 3'd0;
  localparam pc_t PC_TICK_LOOP  = 3'd1;
  localparam pc_t PC_TICK_DONE  = 3'd2;
  localparam pc_t PC_READ       = 3'd3;
  localparam pc_t PC_WRITE      = 3'd4;
  localparam pc_t PC_TAKE       = 3'd5;

  function automatic ctrl_word_t rom_word(input pc_t pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: COND_NONE, target: PC_TICK_START, last: 1'b1};
    unique case (pc)
      PC_TICK_START: w = '{op: OP_TICK_START, cond: COND_TIMER_OFF,
                           target: PC_TICK_DONE, last: 1'b0};
      PC_TICK_LOOP:  w = '{op: OP_COUNT, cond: COND_ACC_GE,
                           target: PC_TICK_LOOP, last: 1'b0};
      PC_TICK_DONE:  w = '{op: OP_NOP, cond: COND_NONE,
                           target: PC_TICK_START, last: 1'b1};
      PC_READ:       w = '{op: OP_READ, cond: COND_NONE,
                           target: PC_TICK_START, last: 1'b1};
      PC_WRITE:      w = '{op: OP_WRITE, cond: COND_NONE,
                           target: PC_TICK_START, last: 1'b1};
      PC_TAKE:       w = '{op: OP_TAKE, cond: COND_NONE,
                           target: PC_TICK_START, last: 1'b1};
      default:       w = '{op: OP_NOP, cond: COND_NONE,
                           target: PC_TICK_START, last: 1'b1};
    endcase
    return w;
  endfunction

  function automatic pc_t entry_of(input mode_t mode);
    pc_t pc;
    unique case (mode)
      MODE_TICK:  pc = PC_TICK_START;
      MODE_READ:  pc = PC_READ;
      MODE_WRITE: pc = PC_WRITE;
      default:    pc = PC_TAKE;
    endcase
    return pc;
  endfunction

  function automatic acc_t period_of(input logic [1:0] sel);
    acc_t p;
    unique case (sel)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      default: p = 11'd256;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[hdl/drtu_ifs.sv]
// ----------------------------------------------------------------------------
// drtu_ifs
// Valid/ready channels of the timer unit: item beats in, result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface drtu_in_if;
  logic            valid;
  logic            ready;
  drtu_pkg::mode_t mode;
  drtu_pkg::addr_t address;
  drtu_pkg::byte_t write_data;
  drtu_pkg::byte_t tick_cycles;

  modport source (output valid, output mode, output address, output write_data,
                  output tick_cycles, input ready);
  modport sink (input valid, input mode, input address, input write_data,
                input tick_cycles, output ready);
endinterface

interface drtu_out_if;
  logic            valid;
  logic            ready;
  drtu_pkg::byte_t read_data;
  logic            interrupt_taken;
  logic            interrupt_pending;

  modport source (output valid, output read_data, output interrupt_taken,
                  output interrupt_pending, input ready);
  modport sink (input valid, input read_data, input interrupt_taken,
                input interrupt_pending, output ready);
endinterface

`default_nettype wire

[hdl/drtu_seq.sv]
// ----------------------------------------------------------------------------
// drtu_seq
// Step counter over the control store: dispatch on the item kind, fetch one
// control word per step, take conditional jumps on datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module drtu_seq (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  input  wire drtu_pkg::mode_t    start_mode,
  input  wire                     step_en,
  input  wire drtu_pkg::seq_status_t status,
  output drtu_pkg::ctrl_word_t    cw,
  output logic                    busy
);
  import drtu_pkg::*;

  pc_t  pc_r,   pc_nxt;
  logic busy_r, busy_nxt;
  logic jump;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= PC_TICK_START;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_comb begin
    cw       = rom_word(pc_r);
    busy     = busy_r;
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    unique case (cw.cond)
      COND_TIMER_OFF: jump = status.timer_off;
      COND_ACC_GE:    jump = status.acc_ge;
      default:        jump = 1'b0;
    endcase
    if (!busy_r) begin
      if (start) begin
        pc_nxt   = entry_of(start_mode);
        busy_nxt = 1'b1;
      end
    end else if (step_en) begin
      if (cw.last) begin
        busy_nxt = 1'b0;
      end else if (jump) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/divider_and_reload_timer_unit.sv]
// ----------------------------------------------------------------------------
// divider_and_reload_timer_unit
// Divider / counter / reload / control timer driven by a small microprogram.
//
// Items arrive on in_ch (valid/ready): tick, bus read, bus write or take
// interrupt. Each item yields exactly one result beat on out_ch holding
// the read byte, the taken flag and the pending interrupt flag.
// One item is worked on at a time; in_ch.ready is high whenever no program
// is running, also while a finished result still waits in the output
// register. Read, write and take run one step; a tick runs a start step,
// one step per counter increment owed (n, up to 79 with the period of 16
// and a large held phase) plus one, and a final step; with the timer
// disabled, it runs the start step and the final step. The counter loop
// sets how long a tick runs. The result is registered and shows on out_ch
// in the cycle after the last step.
// A stalled out_ch holds the result; a finished program waits on its last
// step until the output register frees up.
// Reset clears all timer registers, the interrupt flag and both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module divider_and_reload_timer_unit (
  input  wire  clk,
  input  wire  rst_n,
  drtu_in_if.sink    in_ch,
  drtu_out_if.source out_ch
);
  import drtu_pkg::*;

  ctrl_word_t  cw;
  seq_status_t status;
  logic        busy;
  logic        step_en;
  logic        start;
  logic        fire_last;

  addr_t       addr_r;
  byte_t       data_r;
  byte_t       cycles_r;

  byte_t       div_count_r,   div_count_nxt;
  byte_t       div_phase_r,   div_phase_nxt;
  byte_t       counter_r,     counter_nxt;
  byte_t       reload_r,      reload_nxt;
  logic [2:0]  control_r,     control_nxt;
  logic [9:0]  cnt_phase_r,   cnt_phase_nxt;
  logic        flag_r,        flag_nxt;
  acc_t        acc_r,         acc_nxt;

  logic        out_valid_r;
  byte_t       out_rd_r,      out_rd_nxt;
  logic        out_taken_r,   out_taken_nxt;
  logic        out_pending_r;

  acc_t        period;
  logic [8:0]  div_sum;
  byte_t       read_mux;

  assign start     = in_ch.valid && !busy;
  assign step_en   = busy && !(cw.last && out_valid_r && !out_ch.ready);
  assign fire_last = step_en && cw.last;

  assign in_ch.ready              = !busy;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.read_data         = out_rd_r;
  assign out_ch.interrupt_taken   = out_taken_r;
  assign out_ch.interrupt_pending = out_pending_r;

  assign period           = period_of(control_r[1:0]);
  assign status.timer_off = !control_r[2];
  assign status.acc_ge    = (acc_r >= period);

  drtu_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_mode (in_ch.mode),
    .step_en    (step_en),
    .status     (status),
    .cw         (cw),
    .busy       (busy)
  );

  always_comb begin
    div_sum = {1'b0, div_phase_r} + {1'b0, cycles_r};
    unique case (addr_r)
      ADDR_DIVIDER: read_mux = div_count_r;
      ADDR_COUNTER: read_mux = counter_r;
      ADDR_RELOAD:  read_mux = reload_r;
      ADDR_CONTROL: read_mux = {CTL_UPPER_ONES, control_r};
      default:      read_mux = BYTE_ALL_ONES;
    endcase

    div_count_nxt = div_count_r;
    div_phase_nxt = div_phase_r;
    counter_nxt   = counter_r;
    reload_nxt    = reload_r;
    control_nxt   = control_r;
    cnt_phase_nxt = cnt_phase_r;
    flag_nxt      = flag_r;
    acc_nxt       = acc_r;
    out_rd_nxt    = '0;
    out_taken_nxt = 1'b0;

    if (step_en) begin
      unique case (cw.op)
        OP_TICK_START: begin
          div_phase_nxt = div_sum[7:0];
          if (div_sum[8]) begin
            div_count_nxt = div_count_r + 8'd1;
          end
          acc_nxt = {1'b0, cnt_phase_r} + {3'b000, cycles_r};
        end
        OP_COUNT: begin
          if (status.acc_ge) begin
            acc_nxt = acc_r - period;
            if (counter_r == BYTE_ALL_ONES) begin
              counter_nxt = reload_r;
              flag_nxt    = 1'b1;
            end else begin
              counter_nxt = counter_r + 8'd1;
            end
          end else begin
            cnt_phase_nxt = acc_r[9:0];
          end
        end
        OP_READ: begin
          out_rd_nxt = read_mux;
        end
        OP_WRITE: begin
          unique case (addr_r)
            ADDR_DIVIDER: begin
              div_count_nxt = '0;
              div_phase_nxt = '0;
            end
            ADDR_COUNTER: counter_nxt = data_r;
            ADDR_RELOAD:  reload_nxt  = data_r;
            ADDR_CONTROL: control_nxt = data_r[2:0];
            default:      ;
          endcase
        end
        OP_TAKE: begin
          out_taken_nxt = flag_r;
          flag_nxt      = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_count_r <= '0;
      div_phase_r <= '0;
      counter_r   <= '0;
      reload_r    <= '0;
      control_r   <= '0;
      cnt_phase_r <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_count_r <= div_count_nxt;
      div_phase_r <= div_phase_nxt;
      counter_r   <= counter_nxt;
      reload_r    <= reload_nxt;
      control_r   <= control_nxt;
      cnt_phase_r <= cnt_phase_nxt;
      flag_r      <= flag_nxt;
      if (fire_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (start) begin
      addr_r   <= in_ch.address;
      data_r   <= in_ch.write_data;
      cycles_r <= in_ch.tick_cycles;
    end
    if (fire_last) begin
      out_rd_r      <= out_rd_nxt;
      out_taken_r   <= out_taken_nxt;
      out_pending_r <= flag_nxt;
    end
  end

endmodule

`default_nettype wire
